[hdl/ethl4p_pkg.sv]
// Shared constants and result codes for the Ethernet/IP/L4 header parser.
`default_nettype none

package ethl4p_pkg;

  // Frame byte counter saturation point
  localparam logic [15:0] MAX_FRAME_BYTES     = 16'hFFFF;

  // Fixed header sizes, in bytes
  localparam logic [15:0] ETH_HDR_BYTES       = 16'd14;
  localparam logic [7:0]  ETH_HDR_BYTES_B     = 8'd14;
  localparam logic [7:0]  IPV6_L4_START       = 8'd54;   // 14 + 40
  localparam logic [5:0]  IPV4_MIN_HDR_BYTES  = 6'd20;
  localparam logic [5:0]  TCP_MIN_HDR_BYTES   = 6'd20;
  localparam logic [7:0]  UDP_HDR_BYTES       = 8'd8;
  localparam logic [7:0]  ICMPV4_HEADER_BYTES = 8'd8;
  localparam logic [7:0]  ICMPV6_HEADER_BYTES = 8'd8;

  // Byte positions captured from the frame
  localparam logic [15:0] IDX_ETYPE_HI        = 16'd12;
  localparam logic [15:0] IDX_ETYPE_LO        = 16'd13;
  localparam logic [15:0] IDX_IPV4_IHL        = 16'd14;
  localparam logic [15:0] IDX_IPV4_PROTO      = 16'd23;
  localparam logic [15:0] IDX_IPV6_NXT        = 16'd20;
  localparam logic [15:0] IDX_IPV6_TCP_OFF    = 16'd66;  // 14 + 40 + 12
  localparam logic [15:0] IPV4_TCP_OFF_BASE   = 16'd26;  // 14 + 12

  // EtherTypes
  localparam logic [15:0] ET_IPV4             = 16'h0800;
  localparam logic [15:0] ET_IPV6             = 16'h86DD;
  localparam logic [15:0] ET_ARP              = 16'h0806;

  // IP protocol numbers
  localparam logic [7:0]  IPP_HOPOPT          = 8'd0;
  localparam logic [7:0]  IPP_ICMPV4          = 8'd1;
  localparam logic [7:0]  IPP_TCP             = 8'd6;
  localparam logic [7:0]  IPP_UDP             = 8'd17;
  localparam logic [7:0]  IPP_ROUTING         = 8'd43;
  localparam logic [7:0]  IPP_FRAGMENT        = 8'd44;
  localparam logic [7:0]  IPP_ESP             = 8'd50;
  localparam logic [7:0]  IPP_AH              = 8'd51;
  localparam logic [7:0]  IPP_ICMPV6          = 8'd58;
  localparam logic [7:0]  IPP_DSTOPTS         = 8'd60;

  typedef enum logic [1:0] {
    L3_NONE = 2'd0,
    L3_ARP  = 2'd1,
    L3_IPV4 = 2'd2,
    L3_IPV6 = 2'd3
  } l3_code_t;

  // Shared by l4_kind and ip_protocol
  typedef enum logic [2:0] {
    L4_NONE   = 3'd0,
    L4_TCP    = 3'd1,
    L4_UDP    = 3'd2,
    L4_ICMPV4 = 3'd3,
    L4_ICMPV6 = 3'd4
  } l4_code_t;

endpackage

`default_nettype wire

[hdl/ethernet_ip_l4_header_parser_core.sv]
// Ethernet/IPv4/IPv6/L4 header parser: byte stream in, one classification beat per frame out.
`default_nettype none

// Takes a frame one byte per beat in wire order, with last marking the final byte,
// and gives one result beat per frame: Ethernet presence, L3 kind (ARP, IPv4,
// IPv6), L4 kind and recognised protocol (TCP, UDP, ICMPv4, ICMPv6), and the
// payload offset and length. Rate: one byte per clock, sustained, but for the
// stall below. Each accepted beat is held in an input register, then a single
// pass of capture and classification logic updates the frame state and, on a last
// byte, loads the result register, from which the result is offered.
// Non-last bytes never wait on the result side. The input stalls only when a last
// byte is held in the input register while the previous result is still unclaimed.
// IPv6 extension headers report an unknown protocol; header fields lying past the
// end of a short frame count as absent. The byte count saturates at 65535, and
// later bytes only contribute their last mark.
module ethernet_ip_l4_header_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  // result channel
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             eth_present,
  output logic [1:0]       l3_kind,
  output logic [2:0]       l4_kind,
  output logic [2:0]       ip_protocol,
  output logic [15:0]      payload_offset,
  output logic [15:0]      payload_length
);

  import ethl4p_pkg::*;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;     // held beat is consumed by the parse stage this cycle

  // A non-last beat only updates frame state; a last beat needs the result slot.
  assign s1_fire    = s1_valid && (!s1_last || !result_valid || result_ready);
  assign byte_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [15:0] byte_count;
  logic [15:0] ether_type_value;
  logic [5:0]  ipv4_header_bytes;
  logic [7:0]  ip_next_protocol;
  logic        next_protocol_seen;
  logic [5:0]  tcp_header_bytes;
  logic        tcp_offset_seen;

  logic [15:0] byte_count_next;
  logic [15:0] ether_type_value_next;
  logic [5:0]  ipv4_header_bytes_next;
  logic [7:0]  ip_next_protocol_next;
  logic        next_protocol_seen_next;
  logic [5:0]  tcp_header_bytes_next;
  logic        tcp_offset_seen_next;

  logic        cap_en;
  logic        et_is_v4;
  logic        et_is_v6;
  logic [15:0] v4_tcp_idx;

  // Capture for the byte at position byte_count. Bytes 12/13 never coincide with
  // an IP field position, so the IP captures can look at the stored EtherType.
  always_comb begin
    cap_en     = (byte_count != MAX_FRAME_BYTES);
    et_is_v4   = (ether_type_value == ET_IPV4);
    et_is_v6   = (ether_type_value == ET_IPV6);
    v4_tcp_idx = IPV4_TCP_OFF_BASE + {10'd0, ipv4_header_bytes};

    byte_count_next         = byte_count;
    ether_type_value_next   = ether_type_value;
    ipv4_header_bytes_next  = ipv4_header_bytes;
    ip_next_protocol_next   = ip_next_protocol;
    next_protocol_seen_next = next_protocol_seen;
    tcp_header_bytes_next   = tcp_header_bytes;
    tcp_offset_seen_next    = tcp_offset_seen;

    if (cap_en) begin
      byte_count_next = byte_count + 16'd1;
      if (byte_count == IDX_ETYPE_HI) begin
        ether_type_value_next = {s1_byte, 8'h00};
      end
      if (byte_count == IDX_ETYPE_LO) begin
        ether_type_value_next = {ether_type_value[15:8], s1_byte};
      end
      if (et_is_v4) begin
        if (byte_count == IDX_IPV4_IHL) begin
          ipv4_header_bytes_next = {s1_byte[3:0], 2'b00};
        end
        if (byte_count == IDX_IPV4_PROTO) begin
          ip_next_protocol_next   = s1_byte;
          next_protocol_seen_next = 1'b1;
        end
        // IHL of 5 or more puts the TCP data offset at or beyond byte 46
        if (ipv4_header_bytes >= IPV4_MIN_HDR_BYTES && byte_count == v4_tcp_idx) begin
          tcp_header_bytes_next = {s1_byte[7:4], 2'b00};
          tcp_offset_seen_next  = 1'b1;
        end
      end else if (et_is_v6) begin
        if (byte_count == IDX_IPV6_NXT) begin
          ip_next_protocol_next   = s1_byte;
          next_protocol_seen_next = 1'b1;
        end
        if (byte_count == IDX_IPV6_TCP_OFF) begin
          tcp_header_bytes_next = {s1_byte[7:4], 2'b00};
          tcp_offset_seen_next  = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Classification, from the state as it stands after this byte
  // ---------------------------------------------------------------------------
  logic        c_eth;
  l3_code_t    c_l3;
  l4_code_t    c_l4;
  l4_code_t    c_proto;
  logic [15:0] c_offset;
  logic [15:0] c_length;

  logic        v4;
  logic        ip_et;
  logic        l3_ok;
  logic        ext_hdr;
  logic [7:0]  l4_start;
  logic [7:0]  l4_hdr;
  logic [7:0]  l4_end;
  logic [5:0]  tcp_hdr;
  logic        hdr_ok;
  logic [15:0] len;

  always_comb begin
    len      = byte_count_next;
    v4       = (ether_type_value_next == ET_IPV4);
    ip_et    = v4 || (ether_type_value_next == ET_IPV6);
    l3_ok    = !v4 || ((ipv4_header_bytes_next >= IPV4_MIN_HDR_BYTES) &&
               ({10'd0, ipv4_header_bytes_next} + ETH_HDR_BYTES <= len));
    ext_hdr  = !v4 && (ip_next_protocol_next == IPP_HOPOPT ||
                       ip_next_protocol_next == IPP_ROUTING ||
                       ip_next_protocol_next == IPP_FRAGMENT ||
                       ip_next_protocol_next == IPP_ESP ||
                       ip_next_protocol_next == IPP_AH ||
                       ip_next_protocol_next == IPP_DSTOPTS);
    l4_start = v4 ? (ETH_HDR_BYTES_B + {2'b00, ipv4_header_bytes_next}) : IPV6_L4_START;
    tcp_hdr  = tcp_offset_seen_next ? tcp_header_bytes_next : 6'd0;

    priority if (ip_next_protocol_next == IPP_TCP) begin
      l4_hdr = {2'b00, tcp_hdr};
    end else if (ip_next_protocol_next == IPP_UDP) begin
      l4_hdr = UDP_HDR_BYTES;
    end else if (v4) begin
      l4_hdr = ICMPV4_HEADER_BYTES;
    end else begin
      l4_hdr = ICMPV6_HEADER_BYTES;
    end
    l4_end = l4_start + l4_hdr;

    c_eth    = 1'b0;
    c_l3     = L3_NONE;
    c_l4     = L4_NONE;
    c_proto  = L4_NONE;
    c_offset = 16'd0;
    c_length = 16'd0;
    hdr_ok   = 1'b0;

    if (len >= ETH_HDR_BYTES) begin
      c_eth = 1'b1;
      if (ether_type_value_next == ET_ARP) begin
        c_l3 = L3_ARP;
      end else if (ip_et && len >= ETH_HDR_BYTES + 16'd1) begin
        c_l3 = v4 ? L3_IPV4 : L3_IPV6;
        if (l3_ok && next_protocol_seen_next && !ext_hdr) begin
          priority if (ip_next_protocol_next == IPP_TCP) begin
            c_proto = L4_TCP;
            if (len >= {8'd0, l4_start} + 16'd1) begin
              c_l4   = L4_TCP;
              hdr_ok = (tcp_hdr >= TCP_MIN_HDR_BYTES);
            end
          end else if (ip_next_protocol_next == IPP_UDP) begin
            c_proto = L4_UDP;
            if (len >= {8'd0, l4_start} + 16'd1) begin
              c_l4   = L4_UDP;
              hdr_ok = 1'b1;
            end
          end else if (v4 && ip_next_protocol_next == IPP_ICMPV4) begin
            c_proto = L4_ICMPV4;
            if (len >= {8'd0, l4_end}) begin
              c_l4   = L4_ICMPV4;
              hdr_ok = 1'b1;
            end
          end else if (!v4 && ip_next_protocol_next == IPP_ICMPV6) begin
            c_proto = L4_ICMPV6;
            if (len >= {8'd0, l4_end}) begin
              c_l4   = L4_ICMPV6;
              hdr_ok = 1'b1;
            end
          end else begin
            c_proto = L4_NONE;
          end
          if (hdr_ok && {8'd0, l4_end} <= len) begin
            c_offset = {8'd0, l4_end};
            c_length = len - {8'd0, l4_end};
          end
        end
      end
    end
  end

  // State registers: advance on every consumed beat, clear after a last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      ether_type_value   <= '0;
      ipv4_header_bytes  <= '0;
      ip_next_protocol   <= '0;
      next_protocol_seen <= 1'b0;
      tcp_header_bytes   <= '0;
      tcp_offset_seen    <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        byte_count         <= '0;
        ether_type_value   <= '0;
        ipv4_header_bytes  <= '0;
        ip_next_protocol   <= '0;
        next_protocol_seen <= 1'b0;
        tcp_header_bytes   <= '0;
        tcp_offset_seen    <= 1'b0;
      end else begin
        byte_count         <= byte_count_next;
        ether_type_value   <= ether_type_value_next;
        ipv4_header_bytes  <= ipv4_header_bytes_next;
        ip_next_protocol   <= ip_next_protocol_next;
        next_protocol_seen <= next_protocol_seen_next;
        tcp_header_bytes   <= tcp_header_bytes_next;
        tcp_offset_seen    <= tcp_offset_seen_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic res_load;
  assign res_load = s1_fire && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (res_load) begin
      eth_present    <= c_eth;
      l3_kind        <= c_l3;
      l4_kind        <= c_l4;
      ip_protocol    <= c_proto;
      payload_offset <= c_offset;
      payload_length <= c_length;
    end
  end

`ifndef SYNTH
  // A result only appears after a last byte has gone through the parse stage
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    !result_valid ##1 result_valid |-> $past(s1_valid && s1_last))
    else $error("result beat without a last byte");

  // Input back-pressure only comes from a last byte blocked by an unclaimed result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> s1_valid && s1_last && result_valid && !result_ready)
    else $error("input stalled without cause");

  // No layer-4 header reported for an unknown protocol
  a_l4_needs_proto: assert property (@(posedge clk) disable iff (rst)
    result_valid && ip_protocol == L4_NONE |-> l4_kind == L4_NONE)
    else $error("l4 kind without protocol");

  // Failed checks give both offset and length as zero
  a_len_needs_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && payload_offset == 16'd0 |-> payload_length == 16'd0)
    else $error("payload length without offset");
`endif

endmodule

`default_nettype wire

[tb/ethl4p_checker.sv]
// Checker for the header parser: shadows the frame state, predicts each result beat and compares.
`timescale 1ns / 1ps

module ethl4p_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  input  wire logic        byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire logic        result_valid,
  input  wire logic        result_ready,
  input  wire logic        eth_present,
  input  wire logic [1:0]  l3_kind,
  input  wire logic [2:0]  l4_kind,
  input  wire logic [2:0]  ip_protocol,
  input  wire logic [15:0] payload_offset,
  input  wire logic [15:0] payload_length,
  output int               fail_count,
  output int               frames_outstanding,
  output int               frames_checked,
  output int               l4_frames,
  output int               payload_frames
);

  import ethl4p_pkg::*;

  typedef struct {
    logic        eth;
    l3_code_t    l3;
    l4_code_t    l4;
    l4_code_t    proto;
    logic [15:0] offset;
    logic [15:0] length;
  } frame_class_t;

  frame_class_t frame_class_q[$];
  frame_class_t want;

  // shadow of the per-frame state
  logic [15:0] frame_len;
  logic [15:0] etype;
  logic [5:0]  ip_hdr_len;
  logic [7:0]  next_proto;
  bit          next_proto_seen;
  logic [5:0]  tcp_hdr_len;
  bit          tcp_hdr_seen;

  task clear_frame();
    frame_len       = '0;
    etype           = '0;
    ip_hdr_len      = '0;
    next_proto      = '0;
    next_proto_seen = 1'b0;
    tcp_hdr_len     = '0;
    tcp_hdr_seen    = 1'b0;
  endtask

  task capture_byte(input logic [15:0] idx, input logic [7:0] b);
    if (idx == IDX_ETYPE_HI) etype = {b, 8'h00};
    if (idx == IDX_ETYPE_LO) etype[7:0] = b;
    if (etype == ET_IPV4) begin
      if (idx == IDX_IPV4_IHL) ip_hdr_len = {b[3:0], 2'b00};
      if (idx == IDX_IPV4_PROTO) begin
        next_proto      = b;
        next_proto_seen = 1'b1;
      end
      // data offset sits 12 bytes into the TCP header, only for a sane IHL
      if (ip_hdr_len >= IPV4_MIN_HDR_BYTES &&
          int'(idx) == int'(IPV4_TCP_OFF_BASE) + int'(ip_hdr_len)) begin
        tcp_hdr_len  = {b[7:4], 2'b00};
        tcp_hdr_seen = 1'b1;
      end
    end else if (etype == ET_IPV6) begin
      if (idx == IDX_IPV6_NXT) begin
        next_proto      = b;
        next_proto_seen = 1'b1;
      end
      if (idx == IDX_IPV6_TCP_OFF) begin
        tcp_hdr_len  = {b[7:4], 2'b00};
        tcp_hdr_seen = 1'b1;
      end
    end
  endtask

  function automatic frame_class_t classify_frame(int len);
    frame_class_t r;
    int           l4_start;
    int           hdr;
    bit           v4;
    r.eth    = 1'b0;
    r.l3     = L3_NONE;
    r.l4     = L4_NONE;
    r.proto  = L4_NONE;
    r.offset = '0;
    r.length = '0;
    hdr      = 0;
    if (len < int'(ETH_HDR_BYTES)) return r;
    r.eth = 1'b1;
    if (etype == ET_ARP) begin
      r.l3 = L3_ARP;
      return r;
    end
    if (etype != ET_IPV4 && etype != ET_IPV6) return r;
    if (len < int'(ETH_HDR_BYTES) + 1) return r;
    v4   = (etype == ET_IPV4);
    r.l3 = v4 ? L3_IPV4 : L3_IPV6;
    if (v4) begin
      if (ip_hdr_len < IPV4_MIN_HDR_BYTES) return r;
      l4_start = int'(ETH_HDR_BYTES) + int'(ip_hdr_len);
      if (l4_start > len) return r;
    end else begin
      l4_start = int'(IPV6_L4_START);
    end
    if (!next_proto_seen) return r;
    // extension headers end the IPv6 parse
    if (!v4 && (next_proto == IPP_HOPOPT || next_proto == IPP_ROUTING ||
                next_proto == IPP_FRAGMENT || next_proto == IPP_ESP ||
                next_proto == IPP_AH || next_proto == IPP_DSTOPTS))
      return r;
    if (next_proto == IPP_TCP) begin
      r.proto = L4_TCP;
      if (len < l4_start + 1) return r;
      r.l4 = L4_TCP;
      hdr  = tcp_hdr_seen ? int'(tcp_hdr_len) : 0;
      if (hdr < int'(TCP_MIN_HDR_BYTES)) return r;
    end else if (next_proto == IPP_UDP) begin
      r.proto = L4_UDP;
      if (len < l4_start + 1) return r;
      r.l4 = L4_UDP;
      hdr  = int'(UDP_HDR_BYTES);
    end else if (v4 && next_proto == IPP_ICMPV4) begin
      r.proto = L4_ICMPV4;
      hdr     = int'(ICMPV4_HEADER_BYTES);
      if (len < l4_start + hdr) return r;
      r.l4 = L4_ICMPV4;
    end else if (!v4 && next_proto == IPP_ICMPV6) begin
      r.proto = L4_ICMPV6;
      hdr     = int'(ICMPV6_HEADER_BYTES);
      if (len < l4_start + hdr) return r;
      r.l4 = L4_ICMPV6;
    end else begin
      return r;
    end
    if (l4_start + hdr > len) return r;
    r.offset = 16'(l4_start + hdr);
    r.length = 16'(len - (l4_start + hdr));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      frame_class_q.delete();
      fail_count     = 0;
      frames_checked = 0;
      l4_frames      = 0;
      payload_frames = 0;
    end else begin
      // result side first: a beat leaving now never belongs to a byte taken now
      if (result_valid && result_ready) begin
        if (frame_class_q.size() == 0) begin
          $error("result beat with no frame outstanding");
          fail_count++;
        end else begin
          want = frame_class_q.pop_front();
          frames_checked++;
          if (want.l4 != L4_NONE) l4_frames++;
          if (want.length != 0) payload_frames++;
          if (eth_present !== want.eth) begin
            $error("eth_present: expected %0d, got %0d", want.eth, eth_present);
            fail_count++;
          end
          if (l3_kind !== want.l3) begin
            $error("l3_kind: expected %0d, got %0d", want.l3, l3_kind);
            fail_count++;
          end
          if (l4_kind !== want.l4) begin
            $error("l4_kind: expected %0d, got %0d", want.l4, l4_kind);
            fail_count++;
          end
          if (ip_protocol !== want.proto) begin
            $error("ip_protocol: expected %0d, got %0d", want.proto, ip_protocol);
            fail_count++;
          end
          if (payload_offset !== want.offset) begin
            $error("payload_offset: expected %0d, got %0d", want.offset, payload_offset);
            fail_count++;
          end
          if (payload_length !== want.length) begin
            $error("payload_length: expected %0d, got %0d", want.length, payload_length);
            fail_count++;
          end
        end
      end
      if (byte_valid && byte_ready) begin
        if (frame_len < MAX_FRAME_BYTES) begin
          capture_byte(frame_len, data_byte);
          frame_len++;
        end
        if (last) begin
          frame_class_q.push_back(classify_frame(int'(frame_len)));
          clear_frame();
        end
      end
    end
    frames_outstanding = frame_class_q.size();
  end

endmodule

[tb/testbench.sv]
// Top of the header parser testbench: clock, reset, frame stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;
  import ethl4p_pkg::*;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  data_byte;
  logic        last;
  logic        result_valid;
  logic        result_ready;
  logic        eth_present;
  logic [1:0]  l3_kind;
  logic [2:0]  l4_kind;
  logic [2:0]  ip_protocol;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;

  int fail_count;
  int frames_outstanding;
  int frames_checked;
  int l4_frames;
  int payload_frames;

  // frame under construction; bytes past the buffer are random filler
  logic [7:0] frame_buf [0:255];
  logic [7:0] ext_hdrs  [0:5];

  int bytes_sent;
  int frames_sent;
  bit tx_quiet;   // no sender gaps for the current frame
  bit rx_quiet;   // no receiver stalls for the current stretch

  ethernet_ip_l4_header_parser_core dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .data_byte      (data_byte),
    .last           (last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .eth_present    (eth_present),
    .l3_kind        (l3_kind),
    .l4_kind        (l4_kind),
    .ip_protocol    (ip_protocol),
    .payload_offset (payload_offset),
    .payload_length (payload_length)
  );

  ethl4p_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .byte_valid         (byte_valid),
    .byte_ready         (byte_ready),
    .data_byte          (data_byte),
    .last               (last),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .eth_present        (eth_present),
    .l3_kind            (l3_kind),
    .l4_kind            (l4_kind),
    .ip_protocol        (ip_protocol),
    .payload_offset     (payload_offset),
    .payload_length     (payload_length),
    .fail_count         (fail_count),
    .frames_outstanding (frames_outstanding),
    .frames_checked     (frames_checked),
    .l4_frames          (l4_frames),
    .payload_frames     (payload_frames)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length: mostly none, some short, the odd long one. Long ones
  // outlast the pipe, so both the input register and the result register
  // get caught holding a beat.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One byte beat. Called at a falling edge; returns at the falling edge
  // just after acceptance with valid still high, so a back-to-back byte only
  // changes the payload and valid never drops between beats.
  task send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last       <= is_last;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_frame(input int len);
    for (int i = 0; i < len; i++)
      send_byte((i < 256) ? frame_buf[i] : 8'($urandom), i == len - 1);
    frames_sent++;
  endtask

  // Random bytes with the header fields the parser looks at laid on top.
  // For IPv4 the IHL nibble sets where the TCP data offset byte lands.
  task build_frame(input logic [15:0] et, input logic [3:0] ihl,
                   input logic [7:0] proto, input logic [3:0] doff);
    int l4_start;
    for (int i = 0; i < 256; i++) frame_buf[i] = 8'($urandom);
    frame_buf[12] = et[15:8];
    frame_buf[13] = et[7:0];
    if (et == ET_IPV4) begin
      frame_buf[14] = {4'h4, ihl};
      frame_buf[23] = proto;
      l4_start      = 14 + 4 * int'(ihl);
      frame_buf[l4_start + 12] = {doff, 4'($urandom)};
    end else if (et == ET_IPV6) begin
      frame_buf[14] = {4'h6, 4'($urandom)};
      frame_buf[20] = proto;
      frame_buf[int'(IPV6_L4_START) + 12] = {doff, 4'($urandom)};
    end
  endtask

  // Drop valid and hold off until every outstanding result has been taken.
  task wait_drain();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (frames_outstanding != 0) @(negedge clk);
  endtask

  // Result side: ready toggles at random, independent of valid, with
  // stall-free stretches now and then.
  initial begin
    int stall;
    result_ready = 1'b0;
    rx_quiet     = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
      stall = pick_gap(rx_quiet);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Hard stop; far beyond the slowest legal run, long frames included.
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int          len;
    int          r;
    int          l4_start;
    int          hdr;
    logic [15:0] et;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    int          rand_bytes;
    int          rand_frames;

    rst         = 1'b1;
    byte_valid  = 1'b0;
    data_byte   = 8'h00;
    last        = 1'b0;
    tx_quiet    = 1'b0;
    bytes_sent  = 0;
    frames_sent = 0;
    ext_hdrs[0] = IPP_HOPOPT;
    ext_hdrs[1] = IPP_ROUTING;
    ext_hdrs[2] = IPP_FRAGMENT;
    ext_hdrs[3] = IPP_ESP;
    ext_hdrs[4] = IPP_AH;
    ext_hdrs[5] = IPP_DSTOPTS;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---------------- directed frames ----------------
    // runts: below the Ethernet header everything reads zero
    for (int i = 0; i < 256; i++) frame_buf[i] = 8'h00;
    send_frame(1);
    for (int i = 0; i < 256; i++) frame_buf[i] = 8'hFF;
    send_frame(13);
    send_frame(16);                          // all-ones, unknown EtherType
    // ARP, bare header and padded
    build_frame(ET_ARP, 4'd5, IPP_TCP, 4'd5);
    send_frame(14);
    send_frame(60);
    // unknown EtherType
    build_frame(16'h88CC, 4'd5, IPP_TCP, 4'd5);
    send_frame(60);

    // IPv4: header only, IHL too small, IP header past the frame end
    build_frame(ET_IPV4, 4'd5, IPP_TCP, 4'd5);
    send_frame(14);
    build_frame(ET_IPV4, 4'd4, IPP_TCP, 4'd5);
    send_frame(60);
    build_frame(ET_IPV4, 4'd15, IPP_TCP, 4'd5);
    send_frame(70);
    // protocol byte not yet reached
    build_frame(ET_IPV4, 4'd5, IPP_UDP, 4'd5);
    send_frame(22);
    // TCP: normal, largest headers, short data offset, no L4 byte, offset absent
    build_frame(ET_IPV4, 4'd5, IPP_TCP, 4'd5);
    send_frame(64);
    send_frame(34);
    send_frame(35);
    build_frame(ET_IPV4, 4'd15, IPP_TCP, 4'd15);
    send_frame(139);
    build_frame(ET_IPV4, 4'd5, IPP_TCP, 4'd4);
    send_frame(80);
    // UDP: header exactly filling the frame, header cut short
    build_frame(ET_IPV4, 4'd5, IPP_UDP, 4'd5);
    send_frame(42);
    send_frame(38);
    // ICMPv4 one byte short, then whole; ICMPv6 number on IPv4 is unknown
    build_frame(ET_IPV4, 4'd5, IPP_ICMPV4, 4'd5);
    send_frame(41);
    send_frame(60);
    build_frame(ET_IPV4, 4'd5, IPP_ICMPV6, 4'd5);
    send_frame(60);

    // IPv6: every extension header stops the parse
    for (int i = 0; i < 6; i++) begin
      build_frame(ET_IPV6, 4'd0, ext_hdrs[i], 4'd5);
      send_frame(70);
    end
    // one byte of IP header; next header not yet reached
    build_frame(ET_IPV6, 4'd0, IPP_TCP, 4'd5);
    send_frame(15);
    send_frame(20);
    // TCP data offset byte just past the end, then a full header of 60
    send_frame(66);
    send_frame(100);
    build_frame(ET_IPV6, 4'd0, IPP_TCP, 4'd15);
    send_frame(114);
    build_frame(ET_IPV6, 4'd0, IPP_UDP, 4'd5);
    send_frame(62);
    build_frame(ET_IPV6, 4'd0, IPP_ICMPV6, 4'd5);
    send_frame(61);
    send_frame(62);
    build_frame(ET_IPV6, 4'd0, IPP_ICMPV4, 4'd5);
    send_frame(70);

    // Saturation: exactly at the count limit, then past it, where extra
    // bytes only carry their last mark. Sent without gaps to keep it short.
    tx_quiet = 1'b1;
    build_frame(ET_IPV4, 4'd5, IPP_UDP, 4'd5);
    send_frame(int'(MAX_FRAME_BYTES));
    build_frame(ET_IPV4, 4'd5, IPP_TCP, 4'd5);
    send_frame(int'(MAX_FRAME_BYTES) + 5);
    tx_quiet = 1'b0;

    // sender holds off until the pipe is empty
    wait_drain();

    // ---------------- random frames ----------------
    // Mostly well-formed headers with random content and lengths around
    // the interesting boundaries; some broken lengths and junk EtherTypes.
    rand_bytes  = 0;
    rand_frames = 0;
    while (rand_bytes < 1750 || rand_frames < 48) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      r        = $urandom_range(0, 99);
      ihl      = ($urandom_range(0, 99) < 85) ? 4'd5 : 4'($urandom_range(0, 15));
      doff     = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(5, 15))
                                               : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2: proto = IPP_TCP;
        3, 4:    proto = IPP_UDP;
        5:       proto = IPP_ICMPV4;
        6:       proto = IPP_ICMPV6;
        7:       proto = ext_hdrs[$urandom_range(0, 5)];
        default: proto = 8'($urandom);
      endcase
      if (r < 8)       et = ET_ARP;
      else if (r < 18) et = 16'($urandom);
      else if (r < 60) et = ET_IPV4;
      else             et = ET_IPV6;
      build_frame(et, ihl, proto, doff);
      l4_start = (et == ET_IPV6) ? int'(IPV6_L4_START) : 14 + 4 * int'(ihl);
      hdr      = (proto == IPP_TCP) ? 4 * int'(doff) : 8;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = l4_start + hdr + $urandom_range(0, 60);
        7, 8:                len = $urandom_range(1, l4_start + hdr + 2);
        default:             len = $urandom_range(1, 20);
      endcase
      send_frame(len);
      rand_bytes += len;
      rand_frames++;
      if ($urandom_range(0, 24) == 0) wait_drain();
    end
    tx_quiet = 1'b0;

    // everything in; let the last results drain, then idle before the verdict
    wait_drain();
    repeat (20) @(negedge clk);

    $display("Covered %0d bytes in %0d frames: runts, ARP, IPv4/IPv6 edge lengths, saturation.",
             bytes_sent, frames_sent);
    $display("Checked %0d result beats, %0d with a layer-4 header, %0d with payload bytes.",
             frames_checked, l4_frames, payload_frames);
    if (fail_count == 0 && frames_outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
